/* hw/rtl/gmdfs_pkg.sv */
// ----------------------------------------------------------------------------
// gmdfs_pkg
// Shared constants, codes and helpers for the depth-first maze carver.
// ----------------------------------------------------------------------------
package gmdfs_pkg;

   localparam int MAX_SIDE = 32;
   localparam int COORD_W  = 5;                 // fixed by the port widths
   localparam int SIDE_W   = COORD_W + 1;
   localparam int CELL_AW  = 2 * COORD_W;       // cell index is {y, x}
   localparam int CELLS    = MAX_SIDE * MAX_SIDE;
   localparam int DEPTH_W  = CELL_AW + 1;
   localparam int WALL_W   = 4;
   localparam int CELL_W   = WALL_W + 1;        // {visited, walls}

   localparam logic [WALL_W-1:0] W_TOP    = 4'b0001;
   localparam logic [WALL_W-1:0] W_BOTTOM = 4'b0010;
   localparam logic [WALL_W-1:0] W_LEFT   = 4'b0100;
   localparam logic [WALL_W-1:0] W_RIGHT  = 4'b1000;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_STEP  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // neighbor slots, in candidate order
   localparam logic [1:0] NB_UP    = 2'd0;
   localparam logic [1:0] NB_DOWN  = 2'd1;
   localparam logic [1:0] NB_LEFT  = 2'd2;
   localparam logic [1:0] NB_RIGHT = 2'd3;

   typedef logic [CELL_AW-1:0] cell_addr_type;
   typedef logic [CELL_W-1:0]  cell_word_type;

   function automatic logic [2:0] count4(input logic [3:0] c);
      count4 = 3'(c[0]) + 3'(c[1]) + 3'(c[2]) + 3'(c[3]);
   endfunction

   // rnd mod n for n in 1..4; mod 3 by base-4 digit sum (4 = 1 mod 3)
   function automatic logic [1:0] rnd_mod(input logic [7:0] rnd, input logic [2:0] n);
      logic [3:0] s;
      logic [2:0] t;
      s = 4'(rnd[1:0]) + 4'(rnd[3:2]) + 4'(rnd[5:4]) + 4'(rnd[7:6]);
      t = 3'(s[3:2]) + 3'(s[1:0]);
      if (t >= 3'd3) t = t - 3'd3;
      if (t >= 3'd3) t = t - 3'd3;
      case (n)
         3'd2:    rnd_mod = {1'b0, rnd[0]};
         3'd3:    rnd_mod = t[1:0];
         3'd4:    rnd_mod = rnd[1:0];
         default: rnd_mod = 2'd0;
      endcase
   endfunction

   // slot of the k-th set bit of c, lowest slot first
   function automatic logic [1:0] nth_set(input logic [3:0] c, input logic [1:0] k);
      logic [2:0] seen;
      logic [1:0] res;
      seen = 3'd0;
      res  = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (c[i]) begin
            if (seen == {1'b0, k}) res = 2'(i);
            seen = seen + 3'd1;
         end
      end
      nth_set = res;
   endfunction

endpackage

/* hw/rtl/grid_maze_dfs_carver_core.sv */
// ----------------------------------------------------------------------------
// grid_maze_dfs_carver_core
// Randomized depth-first maze carver over a 32x32 cell store with stack.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel takes one command beat: start at (cell_x, cell_y), carve
//   step using random_value, or read the open walls of a cell. Every command
//   yields exactly one rsp_* beat. csr_* writes grid_size and is always ready;
//   the user must write it only while the block is idle; the block does not enforce this.
// Command sequence (the rsp beat turns valid in the same cycle as req_ready
//   returns, once the rsp register is free):
//   read  cell read, wall latch, response
//   step  stack read, two dual-port neighbor reads, top-cell read, then two
//         cell writes when it carves, or a pop when it backtracks
//   step on an empty stack and unused codes go straight to the response
//   start a clearing pass over all 1024 cells, one cell per cycle on the
//         single write port of the cell memory, then the seed write
// Reset: stack emptied, grid_size back to 32, then the same clearing pass
//   runs with req_ready low before the first command.
// Stall: the result sits in the rsp register; a command can be accepted
//   meanwhile, and its own result waits until the register frees up.
// ----------------------------------------------------------------------------
module grid_maze_dfs_carver_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_action,
   input  logic [gmdfs_pkg::COORD_W-1:0]   req_cell_x,
   input  logic [gmdfs_pkg::COORD_W-1:0]   req_cell_y,
   input  logic [7:0]                      req_random_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gmdfs_pkg::COORD_W-1:0]   rsp_from_x,
   output logic [gmdfs_pkg::COORD_W-1:0]   rsp_from_y,
   output logic [gmdfs_pkg::COORD_W-1:0]   rsp_to_x,
   output logic [gmdfs_pkg::COORD_W-1:0]   rsp_to_y,
   output logic                            rsp_carved,
   output logic                            rsp_finished,
   output logic [gmdfs_pkg::WALL_W-1:0]    rsp_open_walls,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gmdfs_pkg::SIDE_W-1:0]    csr_grid_size
);

   localparam int CW = gmdfs_pkg::COORD_W;
   localparam int SW = gmdfs_pkg::SIDE_W;
   localparam int AW = gmdfs_pkg::CELL_AW;
   localparam int DW = gmdfs_pkg::DEPTH_W;
   localparam int WW = gmdfs_pkg::WALL_W;
   localparam logic [SW-1:0] SIDE_MAX  = SW'(gmdfs_pkg::MAX_SIDE);
   localparam logic [DW-1:0] DEPTH_MAX = DW'(gmdfs_pkg::CELLS);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_NB0   = 4'd2;
   localparam logic [3:0] ST_NB1   = 4'd3;
   localparam logic [3:0] ST_TOP   = 4'd4;
   localparam logic [3:0] ST_PICK  = 4'd5;
   localparam logic [3:0] ST_PUSH  = 4'd6;
   localparam logic [3:0] ST_RDW   = 4'd7;
   localparam logic [3:0] ST_SEED  = 4'd8;
   localparam logic [3:0] ST_RESP  = 4'd9;

   // memories
   gmdfs_pkg::cell_word_type cell_mem [gmdfs_pkg::CELLS];
   gmdfs_pkg::cell_addr_type stack_mem [gmdfs_pkg::CELLS];
   gmdfs_pkg::cell_word_type cell_a_ff, cell_b_ff;
   gmdfs_pkg::cell_addr_type stack_ff;
   gmdfs_pkg::cell_addr_type cell_raddr_a, cell_raddr_b, cell_waddr;
   gmdfs_pkg::cell_word_type cell_wdata;
   logic                     cell_we;
   gmdfs_pkg::cell_addr_type stack_raddr, stack_waddr;
   logic                     stack_we;

   // control
   logic [3:0]    state_ff, state_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [SW-1:0] grid_size_ff;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic          seed_pend_ff, seed_pend_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // command latches
   logic [CW-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [7:0]    rnd_ff, rnd_in;

   // step working set
   gmdfs_pkg::cell_word_type up_ff, down_ff, left_ff, right_ff;
   logic [1:0]    pick_ff, pick_in;
   logic [CW-1:0] to_x_ff, to_x_in, to_y_ff, to_y_in;
   logic [WW-1:0] theirs_ff, theirs_in, nb_walls_ff, nb_walls_in;

   // staged result and output register
   logic [CW-1:0] res_from_x_ff, res_from_x_in, res_from_y_ff, res_from_y_in;
   logic [CW-1:0] res_to_x_ff, res_to_x_in, res_to_y_ff, res_to_y_in;
   logic          res_carved_ff, res_carved_in, res_fin_ff, res_fin_in;
   logic [WW-1:0] res_walls_ff, res_walls_in;
   logic [CW-1:0] rsp_from_x_ff, rsp_from_y_ff, rsp_to_x_ff, rsp_to_y_ff;
   logic          rsp_carved_ff, rsp_fin_ff;
   logic [WW-1:0] rsp_walls_ff;

   logic [SW-1:0] side;
   logic [CW-1:0] tx, ty, sat_x, sat_y;
   logic [SW-1:0] tx6, ty6;
   logic [3:0]    cand;
   logic [2:0]    cand_n;
   logic [1:0]    pick_k, pick_slot;
   logic          out_free, req_fire;
   logic [WW-1:0] mine;
   logic [DW-1:0] depth_dec;

   assign side = (grid_size_ff == '0) ? SW'(1) :
                 (grid_size_ff > SIDE_MAX) ? SIDE_MAX : grid_size_ff;
   assign tx  = stack_ff[CW-1:0];
   assign ty  = stack_ff[AW-1:CW];
   assign tx6 = {1'b0, tx};
   assign ty6 = {1'b0, ty};
   assign sat_x = ({1'b0, req_cell_x} >= side) ? CW'(side - SW'(1)) : req_cell_x;
   assign sat_y = ({1'b0, req_cell_y} >= side) ? CW'(side - SW'(1)) : req_cell_y;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign depth_dec = depth_ff - DW'(1);

   // unvisited in-grid neighbors, in order up, down, left, right
   assign cand[gmdfs_pkg::NB_UP]    = (ty != '0) && (ty6 - SW'(1) < side) &&
                                      (tx6 < side) && !up_ff[WW];
   assign cand[gmdfs_pkg::NB_DOWN]  = (ty6 + SW'(1) < side) && (tx6 < side) && !down_ff[WW];
   assign cand[gmdfs_pkg::NB_LEFT]  = (tx != '0) && (tx6 - SW'(1) < side) &&
                                      (ty6 < side) && !left_ff[WW];
   assign cand[gmdfs_pkg::NB_RIGHT] = (tx6 + SW'(1) < side) && (ty6 < side) && !right_ff[WW];
   assign cand_n    = gmdfs_pkg::count4(cand);
   assign pick_k    = gmdfs_pkg::rnd_mod(rnd_ff, cand_n);
   assign pick_slot = gmdfs_pkg::nth_set(cand, pick_k);

   // memory address selection
   always_comb begin
      cell_raddr_a = stack_ff;
      cell_raddr_b = stack_ff;
      case (state_ff)
         ST_IDLE: cell_raddr_a = {req_cell_y, req_cell_x};
         ST_NB0: begin
            cell_raddr_a = {ty - CW'(1), tx};
            cell_raddr_b = {ty + CW'(1), tx};
         end
         ST_NB1: begin
            cell_raddr_a = {ty, tx - CW'(1)};
            cell_raddr_b = {ty, tx + CW'(1)};
         end
         default: ;
      endcase
   end
   assign stack_raddr = depth_dec[AW-1:0];

   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
      cell_a_ff <= cell_mem[cell_raddr_a];
      cell_b_ff <= cell_mem[cell_raddr_b];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[stack_waddr] <= (state_ff == ST_SEED) ?
                                              {start_y_ff, start_x_ff} : {to_y_ff, to_x_ff};
      stack_ff <= stack_mem[stack_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      clr_cnt_in    = clr_cnt_ff;
      seed_pend_in  = seed_pend_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      rnd_in        = rnd_ff;
      pick_in       = pick_ff;
      to_x_in       = to_x_ff;
      to_y_in       = to_y_ff;
      theirs_in     = theirs_ff;
      nb_walls_in   = nb_walls_ff;
      res_from_x_in = res_from_x_ff;
      res_from_y_in = res_from_y_ff;
      res_to_x_in   = res_to_x_ff;
      res_to_y_in   = res_to_y_ff;
      res_carved_in = res_carved_ff;
      res_fin_in    = res_fin_ff;
      res_walls_in  = res_walls_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cell_we       = 1'b0;
      cell_waddr    = stack_ff;
      cell_wdata    = '0;
      stack_we      = 1'b0;
      stack_waddr   = depth_ff[AW-1:0];
      mine          = '0;

      case (state_ff)
         ST_CLEAR: begin
            cell_we    = 1'b1;
            cell_waddr = clr_cnt_ff;
            cell_wdata = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == '1) begin
               state_in = seed_pend_ff ? ST_SEED : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               rnd_in        = req_random_value;
               res_from_x_in = '0;
               res_from_y_in = '0;
               res_to_x_in   = '0;
               res_to_y_in   = '0;
               res_carved_in = 1'b0;
               res_walls_in  = '0;
               res_fin_in    = (depth_ff == '0);
               case (req_action)
                  gmdfs_pkg::ACT_START: begin
                     start_x_in   = sat_x;
                     start_y_in   = sat_y;
                     seed_pend_in = 1'b1;
                     clr_cnt_in   = '0;
                     state_in     = ST_CLEAR;
                  end
                  gmdfs_pkg::ACT_STEP: begin
                     state_in = (depth_ff == '0) ? ST_RESP : ST_NB0;
                  end
                  gmdfs_pkg::ACT_READ: state_in = ST_RDW;
                  default:             state_in = ST_RESP;
               endcase
            end
         end
         ST_NB0: state_in = ST_NB1;
         ST_NB1: state_in = ST_TOP;
         ST_TOP: state_in = ST_PICK;
         ST_PICK: begin
            res_from_x_in = tx;
            res_from_y_in = ty;
            if (cand_n == '0) begin
               depth_in   = depth_dec;
               res_fin_in = (depth_dec == '0);
               state_in   = ST_RESP;
            end else begin
               pick_in = pick_slot;
               case (pick_slot)
                  gmdfs_pkg::NB_UP: begin
                     mine = gmdfs_pkg::W_TOP;    theirs_in = gmdfs_pkg::W_BOTTOM;
                     to_x_in = tx;  to_y_in = ty - CW'(1);  nb_walls_in = up_ff[WW-1:0];
                  end
                  gmdfs_pkg::NB_DOWN: begin
                     mine = gmdfs_pkg::W_BOTTOM; theirs_in = gmdfs_pkg::W_TOP;
                     to_x_in = tx;  to_y_in = ty + CW'(1);  nb_walls_in = down_ff[WW-1:0];
                  end
                  gmdfs_pkg::NB_LEFT: begin
                     mine = gmdfs_pkg::W_LEFT;   theirs_in = gmdfs_pkg::W_RIGHT;
                     to_x_in = tx - CW'(1);  to_y_in = ty;  nb_walls_in = left_ff[WW-1:0];
                  end
                  default: begin
                     mine = gmdfs_pkg::W_RIGHT;  theirs_in = gmdfs_pkg::W_LEFT;
                     to_x_in = tx + CW'(1);  to_y_in = ty;  nb_walls_in = right_ff[WW-1:0];
                  end
               endcase
               // top cell: port A holds its word this cycle
               cell_we    = 1'b1;
               cell_waddr = stack_ff;
               cell_wdata = {cell_a_ff[WW], cell_a_ff[WW-1:0] | mine};
               state_in   = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cell_we    = 1'b1;
            cell_waddr = {to_y_ff, to_x_ff};
            cell_wdata = {1'b1, nb_walls_ff | theirs_ff};
            if (depth_ff < DEPTH_MAX) begin
               stack_we    = 1'b1;
               stack_waddr = depth_ff[AW-1:0];
               depth_in    = depth_ff + DW'(1);
            end
            res_to_x_in   = to_x_ff;
            res_to_y_in   = to_y_ff;
            res_carved_in = 1'b1;
            res_fin_in    = 1'b0;
            state_in      = ST_RESP;
         end
         ST_RDW: begin
            res_walls_in = cell_a_ff[WW-1:0];
            state_in     = ST_RESP;
         end
         ST_SEED: begin
            cell_we       = 1'b1;
            cell_waddr    = {start_y_ff, start_x_ff};
            cell_wdata    = {1'b1, {WW{1'b0}}};
            stack_we      = 1'b1;
            stack_waddr   = '0;
            depth_in      = DW'(1);
            seed_pend_in  = 1'b0;
            res_from_x_in = start_x_ff;
            res_from_y_in = start_y_ff;
            res_fin_in    = 1'b0;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         depth_ff     <= '0;
         clr_cnt_ff   <= '0;
         seed_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         grid_size_ff <= SIDE_MAX;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         clr_cnt_ff   <= clr_cnt_in;
         seed_pend_ff <= seed_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) grid_size_ff <= csr_grid_size;
      end
   end

   always_ff @(posedge clock) begin
      start_x_ff    <= start_x_in;
      start_y_ff    <= start_y_in;
      rnd_ff        <= rnd_in;
      pick_ff       <= pick_in;
      to_x_ff       <= to_x_in;
      to_y_ff       <= to_y_in;
      theirs_ff     <= theirs_in;
      nb_walls_ff   <= nb_walls_in;
      res_from_x_ff <= res_from_x_in;
      res_from_y_ff <= res_from_y_in;
      res_to_x_ff   <= res_to_x_in;
      res_to_y_ff   <= res_to_y_in;
      res_carved_ff <= res_carved_in;
      res_fin_ff    <= res_fin_in;
      res_walls_ff  <= res_walls_in;
      // neighbor words arrive in the cycle after their address
      if (state_ff == ST_NB1) begin
         up_ff   <= cell_a_ff;
         down_ff <= cell_b_ff;
      end
      if (state_ff == ST_TOP) begin
         left_ff  <= cell_a_ff;
         right_ff <= cell_b_ff;
      end
      if (state_ff == ST_RESP && out_free) begin
         rsp_from_x_ff <= res_from_x_ff;
         rsp_from_y_ff <= res_from_y_ff;
         rsp_to_x_ff   <= res_to_x_ff;
         rsp_to_y_ff   <= res_to_y_ff;
         rsp_carved_ff <= res_carved_ff;
         rsp_fin_ff    <= res_fin_ff;
         rsp_walls_ff  <= res_walls_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_from_x     = rsp_from_x_ff;
   assign rsp_from_y     = rsp_from_y_ff;
   assign rsp_to_x       = rsp_to_x_ff;
   assign rsp_to_y       = rsp_to_y_ff;
   assign rsp_carved     = rsp_carved_ff;
   assign rsp_finished   = rsp_fin_ff;
   assign rsp_open_walls = rsp_walls_ff;

   // stack never grows past the cell count
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_MAX)
      else $error("stack depth beyond cell count");

   // a carve lands on a candidate neighbor; the candidate set holds through the push
   a_pick_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH) |-> cand[pick_ff])
      else $error("carve into a non-candidate neighbor");

   // a carve below full depth pushes exactly one entry
   a_push_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && depth_ff < DEPTH_MAX) |=> depth_ff == $past(depth_ff) + DW'(1))
      else $error("push did not advance the stack");

   // the result register is only loaded when it is free
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff && $stable(rsp_from_x_ff) &&
                                       $stable(rsp_walls_ff))
      else $error("pending result overwritten");

endmodule

/* sim/grid_maze_dfs_carver_core_tb.sv */
// ----------------------------------------------------------------------------
// grid_maze_dfs_carver_core_tb
// Drives start, carve-step, wall-read and unused commands into the maze
// carver under random idling on both channels, predicts every response
// beat from a behavioral copy of the grid, the stack and grid_size, and
// compares each returned beat field by field.
// ----------------------------------------------------------------------------
module grid_maze_dfs_carver_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = gmdfs_pkg::COORD_W;
   localparam int SW = gmdfs_pkg::SIDE_W;
   localparam int WW = gmdfs_pkg::WALL_W;
   localparam int NCELLS = gmdfs_pkg::CELLS;
   localparam int SIDE_LIM = gmdfs_pkg::MAX_SIDE;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 20000;
   localparam int CLEAR_SETTLE = 1100;    // start runs a 1024-cell clearing pass
   localparam int ITEM_TARGET = 550;

   typedef struct packed {
      logic [1:0]    action;
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [7:0]    rnd;
   } carve_cmd_type;

   typedef struct packed {
      logic [CW-1:0] from_x;
      logic [CW-1:0] from_y;
      logic [CW-1:0] to_x;
      logic [CW-1:0] to_y;
      logic          carved;
      logic          finished;
      logic [WW-1:0] walls;
   } carve_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic           req_valid = 1'b0;
   logic           req_ready;
   logic [1:0]     req_action = gmdfs_pkg::ACT_START;
   logic [CW-1:0]  req_cell_x = '0;
   logic [CW-1:0]  req_cell_y = '0;
   logic [7:0]     req_random_value = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   logic [CW-1:0]  rsp_from_x;
   logic [CW-1:0]  rsp_from_y;
   logic [CW-1:0]  rsp_to_x;
   logic [CW-1:0]  rsp_to_y;
   logic           rsp_carved;
   logic           rsp_finished;
   logic [WW-1:0]  rsp_open_walls;
   logic           csr_valid = 1'b0;
   logic           csr_ready;
   logic [SW-1:0]  csr_grid_size = 6'd32;

   // behavioral copy of the carver
   bit            maze_visited [NCELLS];
   logic [WW-1:0] maze_walls [NCELLS];
   int unsigned   maze_path [NCELLS];
   int unsigned   maze_depth = 0;
   logic [SW-1:0] grid_reg = 6'd32;

   carve_cmd_type commands_to_send[$];
   carve_rsp_type carve_results_due[$];
   carve_cmd_type beat_in_flight;
   int commands_issued = 0;
   int results_seen = 0;
   int mismatches = 0;
   int send_idle_pct = 37;
   int recv_idle_pct = 82;
   int quiet_cycles = 0;

   grid_maze_dfs_carver_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_random_value (req_random_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_from_x       (rsp_from_x),
      .rsp_from_y       (rsp_from_y),
      .rsp_to_x         (rsp_to_x),
      .rsp_to_y         (rsp_to_y),
      .rsp_carved       (rsp_carved),
      .rsp_finished     (rsp_finished),
      .rsp_open_walls   (rsp_open_walls),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_grid_size    (csr_grid_size)
   );

   always #1 clock = ~clock;

   function automatic int unsigned side_of(input logic [SW-1:0] v);
      if (v == 0) return 1;
      if (v > SIDE_LIM) return SIDE_LIM;
      return v;
   endfunction

   // Advances the grid copy by one command and returns the beat it yields.
   function automatic carve_rsp_type carve_outcome(input carve_cmd_type c);
      carve_rsp_type r;
      int unsigned side, cx, cy, tx, ty, top, n, pick, ni;
      int unsigned nx[4], ny[4];
      logic [WW-1:0] mine[4], theirs[4];
      r = '0;
      side = side_of(grid_reg);
      cx = c.x;
      cy = c.y;
      n = 0;
      case (c.action)
         gmdfs_pkg::ACT_START: begin
            if (cx >= side) cx = side - 1;
            if (cy >= side) cy = side - 1;
            for (int i = 0; i < NCELLS; i++) begin
               maze_visited[i] = 1'b0;
               maze_walls[i] = '0;
            end
            maze_visited[cy * SIDE_LIM + cx] = 1'b1;
            maze_path[0] = cy * SIDE_LIM + cx;
            maze_depth = 1;
            r.from_x = cx[CW-1:0];
            r.from_y = cy[CW-1:0];
         end
         gmdfs_pkg::ACT_STEP: begin
            if (maze_depth != 0) begin
               top = maze_path[maze_depth - 1];
               tx = top % SIDE_LIM;
               ty = top / SIDE_LIM;
               // candidates must lie inside the grid in use, even if top does not
               if (ty > 0 && ty - 1 < side && tx < side
                   && !maze_visited[(ty - 1) * SIDE_LIM + tx]) begin
                  nx[n] = tx; ny[n] = ty - 1; n++;
                  mine[n-1] = gmdfs_pkg::W_TOP; theirs[n-1] = gmdfs_pkg::W_BOTTOM;
               end
               if (ty + 1 < side && tx < side
                   && !maze_visited[(ty + 1) * SIDE_LIM + tx]) begin
                  nx[n] = tx; ny[n] = ty + 1; n++;
                  mine[n-1] = gmdfs_pkg::W_BOTTOM; theirs[n-1] = gmdfs_pkg::W_TOP;
               end
               if (tx > 0 && tx - 1 < side && ty < side
                   && !maze_visited[ty * SIDE_LIM + tx - 1]) begin
                  nx[n] = tx - 1; ny[n] = ty; n++;
                  mine[n-1] = gmdfs_pkg::W_LEFT; theirs[n-1] = gmdfs_pkg::W_RIGHT;
               end
               if (tx + 1 < side && ty < side
                   && !maze_visited[ty * SIDE_LIM + tx + 1]) begin
                  nx[n] = tx + 1; ny[n] = ty; n++;
                  mine[n-1] = gmdfs_pkg::W_RIGHT; theirs[n-1] = gmdfs_pkg::W_LEFT;
               end
               r.from_x = tx[CW-1:0];
               r.from_y = ty[CW-1:0];
               if (n != 0) begin
                  pick = c.rnd % n;
                  ni = ny[pick] * SIDE_LIM + nx[pick];
                  maze_walls[top] = maze_walls[top] | mine[pick];
                  maze_walls[ni] = maze_walls[ni] | theirs[pick];
                  maze_visited[ni] = 1'b1;
                  if (maze_depth < NCELLS) begin
                     maze_path[maze_depth] = ni;
                     maze_depth++;
                  end
                  r.to_x = nx[pick][CW-1:0];
                  r.to_y = ny[pick][CW-1:0];
                  r.carved = 1'b1;
               end else begin
                  maze_depth--;
               end
            end
         end
         gmdfs_pkg::ACT_READ: begin
            r.walls = maze_walls[cy * SIDE_LIM + cx];
         end
         default: ;
      endcase
      r.finished = (maze_depth == 0);
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      carve_rsp_type due;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            due = carve_outcome(beat_in_flight);
            carve_results_due = {carve_results_due, due};
         end
         if (!req_valid || req_ready) begin
            if (commands_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               beat_in_flight = commands_to_send.pop_front();
               req_action <= beat_in_flight.action;
               req_cell_x <= beat_in_flight.x;
               req_cell_y <= beat_in_flight.y;
               req_random_value <= beat_in_flight.rnd;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      carve_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (carve_results_due.size() == 0) begin
               $error("response beat with no command outstanding");
               mismatches++;
            end else begin
               want = carve_results_due.pop_front();
               check_field("from_x", want.from_x, rsp_from_x);
               check_field("from_y", want.from_y, rsp_from_y);
               check_field("to_x", want.to_x, rsp_to_x);
               check_field("to_y", want.to_y, rsp_to_y);
               check_field("carved", want.carved, rsp_carved);
               check_field("finished", want.finished, rsp_finished);
               check_field("open_walls", want.walls, rsp_open_walls);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic issue(input logic [1:0] act, input int x, input int y, input int rnd);
      carve_cmd_type c;
      c.action = act;
      c.x = x[CW-1:0];
      c.y = y[CW-1:0];
      c.rnd = rnd[7:0];
      commands_to_send = {commands_to_send, c};
      commands_issued++;
   endtask

   task automatic drain();
      while (results_seen != commands_issued) @(posedge clock);
   endtask

   // grid_size only changes with the block idle, clearing pass included
   task automatic retune_grid(input logic [SW-1:0] v);
      drain();
      repeat (CLEAR_SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_grid_size <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      grid_reg = v;
   endtask

   initial begin
      int r, steps, mazes, side;
      logic [SW-1:0] gv;
      for (int i = 0; i < NCELLS; i++) begin
         maze_visited[i] = 1'b0;
         maze_walls[i] = '0;
         maze_path[i] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty stack, reads and unused action before any start
      issue(gmdfs_pkg::ACT_STEP, 0, 0, 255);
      issue(gmdfs_pkg::ACT_READ, 31, 31, 0);
      issue(ACT_UNUSED, 31, 31, 255);
      issue(gmdfs_pkg::ACT_START, 31, 0, 0);
      issue(gmdfs_pkg::ACT_STEP, 0, 0, 0);
      issue(gmdfs_pkg::ACT_STEP, 0, 0, 255);
      issue(ACT_UNUSED, 0, 0, 0);
      issue(gmdfs_pkg::ACT_START, 0, 31, 0);       // restart in the middle of a maze
      issue(gmdfs_pkg::ACT_STEP, 0, 0, 8'h55);
      // shrink under a live stack: top lies outside, so it only pops
      retune_grid(6'd3);
      issue(gmdfs_pkg::ACT_STEP, 0, 0, 0);
      issue(gmdfs_pkg::ACT_STEP, 0, 0, 0);
      issue(gmdfs_pkg::ACT_STEP, 0, 0, 0);
      issue(gmdfs_pkg::ACT_READ, 0, 31, 0);        // stored bits outside the current grid
      retune_grid(6'd0);
      issue(gmdfs_pkg::ACT_START, 31, 31, 0);      // saturates to the single cell
      issue(gmdfs_pkg::ACT_STEP, 0, 0, 7);
      retune_grid(6'd63);
      issue(gmdfs_pkg::ACT_START, 31, 31, 0);
      issue(gmdfs_pkg::ACT_STEP, 0, 0, 8'h80);
      retune_grid(6'd2);
      issue(gmdfs_pkg::ACT_START, 1, 1, 0);
      for (int k = 0; k < 7; k++) issue(gmdfs_pkg::ACT_STEP, 0, 0, $urandom_range(255));
      issue(gmdfs_pkg::ACT_READ, 0, 0, 0);

      // random: mostly complete small mazes with reads and noise mixed in
      while (commands_issued < ITEM_TARGET) begin
         r = $urandom_range(99);
         if (r < 70) gv = 6'($urandom_range(2, 6));
         else if (r < 80) gv = 6'($urandom_range(7, 9));
         else if (r < 85) gv = 6'($urandom_range(0, 1));
         else if (r < 92) gv = 6'($urandom_range(33, 63));
         else gv = 6'($urandom_range(10, 32));
         retune_grid(gv);
         if (commands_issued < 200) begin
            send_idle_pct = 37; recv_idle_pct = 82;
         end else if (commands_issued < 380) begin
            send_idle_pct = 82; recv_idle_pct = 37;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         side = side_of(gv);
         steps = 2 * side * side + 2;
         if (steps > 70) steps = 70;
         mazes = $urandom_range(1, 2);
         for (int m = 0; m < mazes && commands_issued < ITEM_TARGET; m++) begin
            // now and then keep the old stack so a resized grid is walked
            if (m != 0 || $urandom_range(99) >= 20)
               issue(gmdfs_pkg::ACT_START, $urandom_range(31), $urandom_range(31),
                     $urandom_range(255));
            for (int k = 0; k < steps && commands_issued < ITEM_TARGET; k++) begin
               r = $urandom_range(99);
               if (r < 9) issue(gmdfs_pkg::ACT_READ, $urandom_range(31), $urandom_range(31),
                                $urandom_range(255));
               else if (r < 12) issue(ACT_UNUSED, $urandom_range(31), $urandom_range(31),
                                      $urandom_range(255));
               else if (r < 13) issue(gmdfs_pkg::ACT_START, $urandom_range(31),
                                      $urandom_range(31), $urandom_range(255));
               else issue(gmdfs_pkg::ACT_STEP, $urandom_range(31), $urandom_range(31),
                          $urandom_range(255));
               if (m == 0 && k == steps / 2) drain();   // sender holds off
            end
         end
      end

      drain();
      repeat (50) @(posedge clock);
      if (carve_results_due.size() != 0) begin
         $error("%0d response beats never arrived", carve_results_due.size());
         mismatches++;
      end
      if (mismatches == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
